>>> sv/asseq_pkg.sv
// Shared types, codes and decode functions of the airspeed sensor sample sequencer.
package asseq_pkg;

	localparam int TIME_WIDTH_DEFAULT = 32;

	localparam logic [7:0]  COLLECT_DELAY_RESET = 8'd10;
	localparam logic [15:0] STALE_LIMIT_RESET   = 16'd100;

	// Configuration register indexes.
	localparam logic REG_COLLECT_DELAY = 1'b0;
	localparam logic REG_STALE_LIMIT   = 1'b1;

	// Input item kinds. The last code is reserved and changes nothing.
	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_MEASURE  = 2'd1;
	localparam logic [1:0] ACT_READ     = 2'd2;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	// Bus requests on a tick.
	localparam logic [1:0] REQ_NONE    = 2'd0;
	localparam logic [1:0] REQ_MEASURE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic [13:0] PRESSURE_MID = 14'd8192;
	localparam int          TEMP_DIVISOR = 2047;

	typedef struct packed {
		logic [7:0]  collect_delay_ms;
		logic [15:0] stale_limit_ms;
	} asseq_cfg_t;

	// Distance of the raw 14-bit pressure from mid-scale.
	function automatic logic [13:0] pressure_distance(input logic [13:0] praw);
		logic [13:0] distance;
		if (praw[13]) begin
			distance = {1'b0, praw[12:0]};
		end else begin
			distance = PRESSURE_MID - praw;
		end
		return distance;
	endfunction

	// (200 * traw) / 2047 - 50. The quotient estimate p >> 11 is low by at most one,
	// since the remainder p - q0 * 2047 = (p mod 2048) + q0 stays below twice the divisor.
	function automatic logic signed [8:0] temperature_degc(input logic [10:0] traw);
		logic [18:0] prod;
		logic [7:0]  q0;
		logic [11:0] rem;
		logic [7:0]  quot;
		prod = {1'b0, traw, 7'd0} + {2'd0, traw, 6'd0} + {5'd0, traw, 3'd0};
		q0   = prod[18:11];
		rem  = {1'b0, prod[10:0]} + {4'd0, q0};
		quot = (rem >= 12'(TEMP_DIVISOR)) ? q0 + 8'd1 : q0;
		return $signed({1'b0, quot}) - 9'sd50;
	endfunction

endpackage

>>> sv/asseq_in_if.sv
// Input channel of the sequencer: tick, measure outcome or read response.
interface asseq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       bus_ok;
	logic [7:0] byte_zero;
	logic [7:0] byte_one;
	logic [7:0] byte_two;
	logic [7:0] byte_three;

	modport source (
		output valid, action, bus_ok, byte_zero, byte_one, byte_two, byte_three,
		input  ready
	);
	modport sink (
		input  valid, action, bus_ok, byte_zero, byte_one, byte_two, byte_three,
		output ready
	);
endinterface

>>> sv/asseq_out_if.sv
// Result channel of the sequencer: bus request and current sample.
interface asseq_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        bus_request;
	logic [13:0]       pressure_counts;
	logic signed [8:0] temperature_c;
	logic              sample_fresh;

	modport source (
		output valid, bus_request, pressure_counts, temperature_c, sample_fresh,
		input  ready
	);
	modport sink (
		input  valid, bus_request, pressure_counts, temperature_c, sample_fresh,
		output ready
	);
endinterface

>>> sv/asseq_regs.sv
// APB configuration registers of the sequencer.
module asseq_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output asseq_pkg::asseq_cfg_t cfg
);
	import asseq_pkg::*;

	logic [7:0]  collect_delay_q;
	logic [15:0] stale_limit_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collect_delay_q <= COLLECT_DELAY_RESET;
			stale_limit_q   <= STALE_LIMIT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_COLLECT_DELAY: collect_delay_q <= pwdata[7:0];
				REG_STALE_LIMIT:   stale_limit_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLLECT_DELAY: prdata = {24'd0, collect_delay_q};
			REG_STALE_LIMIT:   prdata = {16'd0, stale_limit_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.collect_delay_ms = collect_delay_q;
	assign cfg.stale_limit_ms   = stale_limit_q;
endmodule

>>> sv/asseq_core.sv
// Input register, sequencing state and decode, and the result register.
module asseq_core #(
	parameter int TIME_WIDTH = asseq_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  asseq_pkg::asseq_cfg_t cfg,
	asseq_in_if.sink              item,
	asseq_out_if.source           result
);
	import asseq_pkg::*;

	typedef logic [TIME_WIDTH-1:0] tm_t;

	// Input register.
	logic       valid_s1;
	logic [1:0] action_s1;
	logic       ok_s1;
	logic [7:0] b0_s1, b1_s1, b2_s1, b3_s1;

	// Sequencing state.
	tm_t               now_q, start_q, last_q;
	logic              pending_q;
	logic [13:0]       pressure_q;
	logic signed [8:0] temp_q;

	// Result register.
	logic              res_valid_q;
	logic [1:0]        res_request_q;
	logic              res_fresh_q;

	logic              advance, fire;
	logic              tick, keep;
	tm_t               now_nx, last_nx, elapsed, age;
	logic [1:0]        request;
	logic [13:0]       pressure_nx;
	logic signed [8:0] temp_nx;

	// The result register frees up when it is empty or its beat is taken.
	assign advance    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			action_s1 <= item.action;
			ok_s1     <= item.bus_ok;
			b0_s1     <= item.byte_zero;
			b1_s1     <= item.byte_one;
			b2_s1     <= item.byte_two;
			b3_s1     <= item.byte_three;
		end
	end

	always_comb begin
		tick    = (action_s1 == ACT_TICK);
		now_nx  = tick ? now_q + tm_t'(1) : now_q;
		elapsed = now_nx - start_q;
		request = REQ_NONE;
		if (tick) begin
			if (!pending_q) begin
				request = REQ_MEASURE;
			end else if (elapsed > tm_t'(cfg.collect_delay_ms)) begin
				request = REQ_READ;
			end
		end
		// Status codes 2 and 3 have the top bit set and reject the sample.
		keep        = (action_s1 == ACT_READ) && ok_s1 && !b0_s1[7];
		pressure_nx = keep ? pressure_distance({b0_s1[5:0], b1_s1}) : pressure_q;
		temp_nx     = keep ? temperature_degc({b2_s1, b3_s1[7:5]}) : temp_q;
		last_nx     = keep ? now_nx : last_q;
		age         = now_nx - last_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			start_q    <= '0;
			last_q     <= '0;
			pending_q  <= 1'b0;
			pressure_q <= '0;
			temp_q     <= '0;
		end else if (fire) begin
			now_q      <= now_nx;
			last_q     <= last_nx;
			pressure_q <= pressure_nx;
			temp_q     <= temp_nx;
			case (action_s1)
				ACT_MEASURE: begin
					pending_q <= ok_s1;
					if (ok_s1) begin
						start_q <= now_q;
					end
				end
				ACT_READ: pending_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_request_q <= request;
			res_fresh_q   <= (age <= tm_t'(cfg.stale_limit_ms));
		end
	end

	assign result.valid           = res_valid_q;
	assign result.bus_request     = res_request_q;
	assign result.pressure_counts = pressure_q;
	assign result.temperature_c   = temp_q;
	assign result.sample_fresh    = res_fresh_q;
endmodule

>>> sv/airspeed_sensor_sample_sequencer.sv
// Top level of the airspeed sensor sample sequencer.
//
//   channel  dir  handshake                 beat
//   item     in   valid / ready             action, bus_ok, byte_zero..byte_three
//   result   out  valid / ready             bus_request, pressure_counts,
//                                           temperature_c, sample_fresh
//   apb      in   psel, penable, pready     collect_delay_ms @0, stale_limit_ms @4
//
// An item is taken into the input register, then decoded and applied to the
// state as its result beat is loaded into the result register. One item per
// cycle is sustained while results are taken; the only loop is the state update
// itself. A stall on the result side holds the result register and then the input
// register, so ready drops only when both are full. Reset is asynchronous and
// clears the time counters, the stores and the pending flag with no clearing pass.
module airspeed_sensor_sample_sequencer #(
	parameter int TIME_WIDTH = asseq_pkg::TIME_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	asseq_in_if.sink    item,
	asseq_out_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import asseq_pkg::*;

	asseq_cfg_t cfg;

	asseq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asseq_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);
endmodule

>>> dv/tb_airspeed_sensor_sample_sequencer.sv
// Self-checking testbench of the airspeed sensor sample sequencer with an in-bench predictor.
module tb_airspeed_sensor_sample_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import asseq_pkg::*;

	typedef struct packed {
		logic [1:0] action;
		logic       bus_ok;
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
	} sensor_item_t;

	typedef struct packed {
		logic [1:0]        bus_request;
		logic [13:0]       pressure_counts;
		logic signed [8:0] temperature_c;
		logic              sample_fresh;
	} sample_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	asseq_in_if  item_ch ();
	asseq_out_if result_ch ();

	airspeed_sensor_sample_sequencer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch.sink),
		.result  (result_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// Predicted sequencer state and configuration.
	logic [31:0]       clock_ms;
	logic [31:0]       conv_start_ms;
	logic              conv_pending;
	logic [31:0]       sample_time_ms;
	logic [13:0]       press_dist;
	logic signed [8:0] temp_degc;
	logic [7:0]        collect_delay;
	logic [15:0]       stale_limit;

	sample_beat_t expected_beats[$];

	int failures           = 0;
	int beats_checked      = 0;
	int items_sent         = 0;
	int read_requests      = 0;
	int samples_kept       = 0;
	int samples_rejected   = 0;
	int input_stall_cycles = 0;
	int sender_idle_pct    = 0;
	int recv_stall_pct     = 0;
	int hold_left          = 0;

	function automatic sample_beat_t advance_sequencer(input sensor_item_t it);
		sample_beat_t beat;
		int           praw;
		int           traw;
		logic [31:0]  age;
		beat = '0;
		beat.bus_request = REQ_NONE;
		case (it.action)
			ACT_TICK: begin
				clock_ms = clock_ms + 32'd1;
				if (!conv_pending) begin
					beat.bus_request = REQ_MEASURE;
				end else if ((clock_ms - conv_start_ms) > {24'd0, collect_delay}) begin
					beat.bus_request = REQ_READ;
					read_requests++;
				end
			end
			ACT_MEASURE: begin
				conv_pending = it.bus_ok;
				if (it.bus_ok) begin
					conv_start_ms = clock_ms;
				end
			end
			ACT_READ: begin
				conv_pending = 1'b0;
				// Status 2 and 3 mark a stale or faulted conversion and are dropped.
				if (it.bus_ok && !it.byte_zero[7]) begin
					praw = int'({it.byte_zero[5:0], it.byte_one});
					traw = int'({it.byte_two, it.byte_three[7:5]});
					press_dist = 14'((praw >= int'(PRESSURE_MID)) ?
						praw - int'(PRESSURE_MID) : int'(PRESSURE_MID) - praw);
					temp_degc = 9'((200 * traw) / TEMP_DIVISOR - 50);
					sample_time_ms = clock_ms;
					samples_kept++;
				end else if (it.bus_ok) begin
					samples_rejected++;
				end
			end
			default: begin
			end
		endcase
		age = clock_ms - sample_time_ms;
		beat.pressure_counts = press_dist;
		beat.temperature_c   = temp_degc;
		beat.sample_fresh    = (age <= {16'd0, stale_limit});
		return beat;
	endfunction

	function automatic void report_failure(input string msg);
		failures++;
		if (failures <= 10) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endfunction

	function automatic sensor_item_t make_item(input logic [1:0] action, input logic ok,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3);
		sensor_item_t it;
		it.action     = action;
		it.bus_ok     = ok;
		it.byte_zero  = b0;
		it.byte_one   = b1;
		it.byte_two   = b2;
		it.byte_three = b3;
		return it;
	endfunction

	// Offers one item, waits until the sequencer accepts it and queues its prediction.
	task automatic offer_sensor_item(input sensor_item_t it, output sample_beat_t predicted);
		@(negedge clk);
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			do begin
				@(negedge clk);
			end while ($urandom_range(0, 99) < sender_idle_pct);
		end
		item_ch.valid      <= 1'b1;
		item_ch.action     <= it.action;
		item_ch.bus_ok     <= it.bus_ok;
		item_ch.byte_zero  <= it.byte_zero;
		item_ch.byte_one   <= it.byte_one;
		item_ch.byte_two   <= it.byte_two;
		item_ch.byte_three <= it.byte_three;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
		predicted = advance_sequencer(it);
		expected_beats.push_back(predicted);
		items_sent++;
	endtask

	task automatic send_plain(input sensor_item_t it);
		sample_beat_t ignored;
		offer_sensor_item(it, ignored);
	endtask

	// Stops offering and waits until every predicted beat has been checked.
	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (idx == REG_COLLECT_DELAY) begin
			collect_delay = value[7:0];
		end else begin
			stale_limit = value[15:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] delay_ms, input logic [15:0] limit_ms);
		wait_drained();
		write_register(REG_COLLECT_DELAY, {24'd0, delay_ms});
		write_register(REG_STALE_LIMIT, {16'd0, limit_ms});
	endtask

	// Mostly follows the requests the way a bus driver would, with some noise mixed in.
	task automatic run_sessions(input int count);
		sensor_item_t it;
		sample_beat_t beat;
		logic [1:0]   next_kind;
		int           roll;
		next_kind = ACT_TICK;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			it.byte_zero  = 8'($urandom);
			it.byte_one   = 8'($urandom);
			it.byte_two   = 8'($urandom);
			it.byte_three = 8'($urandom);
			it.bus_ok     = 1'($urandom_range(0, 1));
			if (roll < 8) begin
				it.action = 2'($urandom_range(0, 3));
			end else begin
				it.action = next_kind;
				if (next_kind != ACT_TICK) begin
					it.bus_ok = ($urandom_range(0, 9) != 0);
				end
				if (next_kind == ACT_READ) begin
					it.byte_zero[7:6] = ($urandom_range(0, 9) < 8) ?
						2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
				end
			end
			offer_sensor_item(it, beat);
			if (it.action == ACT_TICK) begin
				if (beat.bus_request == REQ_MEASURE) begin
					next_kind = ACT_MEASURE;
				end else if (beat.bus_request == REQ_READ) begin
					next_kind = ACT_READ;
				end else begin
					next_kind = ACT_TICK;
				end
			end else if (it.action == ACT_READ) begin
				next_kind = ACT_MEASURE;
			end else begin
				next_kind = ACT_TICK;
			end
		end
	endtask

	// Reset values: first tick asks for a measure, the read comes after more than 10 ms.
	task automatic test_reset_defaults();
		send_plain(make_item(ACT_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_MEASURE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
		repeat (11) send_plain(make_item(ACT_TICK, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
	endtask

	task automatic test_decode_cases();
		configure(8'd0, 16'd1);
		send_plain(make_item(ACT_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		// A failed measure leaves nothing pending, so the next tick asks again.
		send_plain(make_item(ACT_MEASURE, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_MEASURE, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
		send_plain(make_item(ACT_READ, 1'b1, 8'h7F, 8'hFF, 8'hFF, 8'hFF));
		send_plain(make_item(ACT_READ, 1'b1, 8'h20, 8'h00, 8'h80, 8'h00));
		send_plain(make_item(ACT_READ, 1'b1, 8'h80, 8'h12, 8'h34, 8'h56));
		send_plain(make_item(ACT_READ, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_plain(make_item(ACT_READ, 1'b1, 8'h1F, 8'hFF, 8'h3C, 8'hE0));
		send_plain(make_item(ACT_READ, 1'b0, 8'h05, 8'h55, 8'h55, 8'h55));
		repeat (3) send_plain(make_item(ACT_TICK, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
		// The reserved action changes nothing.
		send_plain(make_item(ACT_RESERVED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
	endtask

	task automatic test_no_idling();
		configure(8'($urandom_range(0, 6)), 16'($urandom_range(0, 30)));
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		run_sessions(400);
	endtask

	task automatic test_sender_gaps();
		configure(8'd0, 16'hFFFF);
		sender_idle_pct = 48;
		recv_stall_pct  = 0;
		run_sessions(300);
	endtask

	task automatic test_receiver_stalls();
		configure(8'hFF, 16'd0);
		sender_idle_pct = 0;
		recv_stall_pct  = 48;
		run_sessions(300);
	endtask

	task automatic test_both_idle();
		configure(8'($urandom_range(1, 20)), 16'($urandom_range(5, 60)));
		sender_idle_pct = 16;
		recv_stall_pct  = 16;
		run_sessions(350);
	endtask

	// A long result stall fills the pipeline and must push back on the input.
	task automatic test_backpressure();
		configure(8'($urandom_range(0, 4)), 16'($urandom_range(0, 10)));
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left       = 300;
		run_sessions(150);
		wait_drained();
		recv_stall_pct = 48;
		run_sessions(100);
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : beat_checker
		sample_beat_t got;
		sample_beat_t want;
		if (arst_n) begin
			if (item_ch.valid && !item_ch.ready) begin
				input_stall_cycles++;
			end
			if (result_ch.valid && result_ch.ready) begin
				got.bus_request     = result_ch.bus_request;
				got.pressure_counts = result_ch.pressure_counts;
				got.temperature_c   = result_ch.temperature_c;
				got.sample_fresh    = result_ch.sample_fresh;
				if (expected_beats.size() == 0) begin
					report_failure($sformatf("result beat with none expected: req %0d p %0d t %0d f %0d",
						got.bus_request, got.pressure_counts, got.temperature_c,
						got.sample_fresh));
				end else begin
					want = expected_beats.pop_front();
					beats_checked++;
					if (got !== want) begin
						report_failure($sformatf(
							"beat %0d: req %0d/%0d press %0d/%0d temp %0d/%0d fresh %0d/%0d (exp/got)",
							beats_checked, want.bus_request, got.bus_request,
							want.pressure_counts, got.pressure_counts, want.temperature_c,
							got.temperature_c, want.sample_fresh, got.sample_fresh));
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d beats outstanding", expected_beats.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		item_ch.valid      = 1'b0;
		item_ch.action     = ACT_TICK;
		item_ch.bus_ok     = 1'b0;
		item_ch.byte_zero  = '0;
		item_ch.byte_one   = '0;
		item_ch.byte_two   = '0;
		item_ch.byte_three = '0;
		clock_ms       = '0;
		conv_start_ms  = '0;
		conv_pending   = 1'b0;
		sample_time_ms = '0;
		press_dist     = '0;
		temp_degc      = '0;
		collect_delay  = COLLECT_DELAY_RESET;
		stale_limit    = STALE_LIMIT_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_decode_cases();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d items and checked %0d result beats over five idle patterns.",
			items_sent, beats_checked);
		$display("Read requests %0d, samples kept %0d, rejected %0d, input stall cycles %0d.",
			read_requests, samples_kept, samples_rejected, input_stall_cycles);
		if (expected_beats.size() != 0) begin
			report_failure($sformatf("%0d expected beats never arrived", expected_beats.size()));
		end
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures", failures);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
